// ===== src/coherent_template_hum_removal_macros.svh =====
// assertion macros for the hum removal block
// used by coherent_template_hum_removal; no other dependencies
`ifndef COHERENT_TEMPLATE_HUM_REMOVAL_MACROS_SVH
`define COHERENT_TEMPLATE_HUM_REMOVAL_MACROS_SVH

`ifndef SYNTHESIS
`define CTHR_ASSERT_IMPL(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("cthr assertion failed");
`define CTHR_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("cthr assertion failed");
`else
`define CTHR_ASSERT_IMPL(name, ck, rs, ante, cons)
`define CTHR_ASSERT_NEXT(name, ck, rs, ante, cons)
`endif

`endif

// ===== src/cthr_pkg.sv =====
// shared constants and controller/datapath interface types
// no dependencies
`default_nettype none

package cthr_pkg;

  localparam int SPACING_DEF      = 4;
  localparam int TEMPLATE_LEN_DEF = 64;
  localparam int SAMPLE_W         = 8;
  localparam int FILT_W           = 9;
  localparam int QUOT_W           = 8;

  typedef struct packed {
    logic accept;
    logic read_step;
    logic acc;
    logic capture;
    logic div_step;
    logic load_out;
  } cthr_cmd_t;

  typedef struct packed {
    logic warm;
  } cthr_status_t;

endpackage

`default_nettype wire

// ===== src/cthr_ctrl.sv =====
// sequencing controller: accept, ring read sweep, template mean step, delivery
// depends on cthr_pkg
`default_nettype none

module cthr_ctrl
  import cthr_pkg::*;
#(
  parameter int TEMPLATE_LEN = TEMPLATE_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_stall,
  output logic         filtered_valid,
  input  logic         filtered_stall,
  input  cthr_status_t status,
  output cthr_cmd_t    cmd
);

  localparam int CNT_W = $clog2(TEMPLATE_LEN);
  localparam logic [CNT_W-1:0] LAST_RD = CNT_W'(TEMPLATE_LEN - 1);

  typedef enum logic [2:0] {
    IDLE,
    READ,
    DRAIN,
    DIVIDE,
    DELIVER
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_pend;
  logic             out_free;

  assign out_free     = !filtered_valid || !filtered_stall;
  assign sample_stall = (state != IDLE);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == IDLE) && sample_valid;
    cmd.read_step = (state == READ);
    cmd.acc       = rd_pend;
    cmd.capture   = (state == DRAIN);
    cmd.div_step  = (state == DIVIDE);
    cmd.load_out  = (state == DELIVER) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      rd_cnt         <= '0;
      rd_pend        <= 1'b0;
      filtered_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.read_step;
      if (cmd.load_out) begin
        filtered_valid <= 1'b1;
      end else if (!filtered_stall) begin
        filtered_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.accept && status.warm) begin
            state  <= READ;
            rd_cnt <= '0;
          end
        end
        READ: begin
          if (rd_cnt == LAST_RD) begin
            state <= DRAIN;
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        DRAIN: begin
          state <= DIVIDE;
        end
        DIVIDE: begin
          state <= DELIVER;
        end
        DELIVER: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cthr_dp.sv =====
// datapath: sample ring, read address stepping, accumulator, reciprocal mean
// depends on cthr_pkg
`default_nettype none

module cthr_dp
  import cthr_pkg::*;
#(
  parameter int SPACING      = SPACING_DEF,
  parameter int TEMPLATE_LEN = TEMPLATE_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [SAMPLE_W-1:0]      sample,
  output logic signed [FILT_W-1:0] filtered,
  input  cthr_cmd_t                cmd,
  output cthr_status_t             status
);

  localparam int RING_LEN    = SPACING * (2 * TEMPLATE_LEN - 1);
  localparam int HALF        = SPACING * (TEMPLATE_LEN - 1);
  localparam int PTR_W       = $clog2(RING_LEN);
  localparam int SUM_W       = SAMPLE_W + $clog2(TEMPLATE_LEN);
  localparam int RECIP_SHIFT = SUM_W + $clog2(TEMPLATE_LEN);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam longint RECIP_FULL =
    ((longint'(1) << RECIP_SHIFT) + longint'(TEMPLATE_LEN) - 1) / longint'(TEMPLATE_LEN);
  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(RING_LEN - 1);
  localparam logic [PTR_W-1:0]   PTR_HALF  = PTR_W'(HALF);
  localparam logic [PTR_W-1:0]   STEP      = PTR_W'(SPACING);
  localparam logic [PTR_W-1:0]   STEP_WRAP = PTR_W'(RING_LEN - SPACING);
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_FULL);

  logic [SAMPLE_W-1:0] ring [RING_LEN];
  logic [SAMPLE_W-1:0] rdata;
  logic [PTR_W-1:0]    wp;
  logic [PTR_W-1:0]    raddr;
  logic [PTR_W-1:0]    raddr_next;
  logic                warmed;
  logic [SUM_W-1:0]    sum;
  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot;
  logic [SAMPLE_W-1:0] delayed;

  assign status.warm = warmed || (wp == PTR_HALF);
  assign raddr_next  = (raddr >= STEP) ? (raddr - STEP) : (raddr + STEP_WRAP);
  assign prod        = PROD_W'(sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[wp] <= sample;
    end
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      warmed <= 1'b0;
    end else if (cmd.accept) begin
      wp     <= (wp == PTR_LAST) ? '0 : wp + 1'b1;
      warmed <= status.warm;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      raddr <= wp;
      sum   <= '0;
      quot  <= '0;
    end else begin
      if (cmd.read_step) begin
        raddr <= raddr_next;
      end
      if (cmd.acc) begin
        sum <= sum + SUM_W'(rdata);
      end else if (cmd.div_step) begin
        quot <= prod[RECIP_SHIFT +: QUOT_W];
      end
    end
    if (cmd.capture) begin
      delayed <= rdata;
    end
    if (cmd.load_out) begin
      filtered <= $signed({1'b0, delayed}) - $signed({1'b0, quot});
    end
  end

endmodule

`default_nettype wire

// ===== src/coherent_template_hum_removal.sv =====
// Mains hum removal by coherent template subtraction, one 8-bit sample per item.
// Input channel: sample with sample_valid / sample_stall; an item is taken at a
// clock edge with sample_valid high and sample_stall low.
// Output channel: filtered (9-bit two's complement) with filtered_valid /
// filtered_stall; the result sits in an output register until taken.
// Warm-up: the first SPACING*(TEMPLATE_LEN-1) samples only fill the ring and give
// no result; they are taken one per cycle.
// After warm-up every sample gives one result. The ring memory is read once per
// cycle, TEMPLATE_LEN reads per item, then one reciprocal multiply forms the
// template mean. The block takes no new item until that result has been loaded
// into the output register; sample_stall stays high meanwhile.
// While the receiver stalls, a finished result waits in the output register and
// the next item is worked on; that item then holds in the delivery step until the
// output register frees, with sample_stall high.
// Reset (rst, synchronous) clears the write pointer, warm-up flag and handshake
// state; ring contents are not cleared and are never read before being written.
// depends on cthr_pkg, cthr_ctrl, cthr_dp and the macros header
`default_nettype none

`include "coherent_template_hum_removal_macros.svh"

module coherent_template_hum_removal
  import cthr_pkg::*;
#(
  parameter int SPACING      = SPACING_DEF,
  parameter int TEMPLATE_LEN = TEMPLATE_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic [SAMPLE_W-1:0]      sample,
  output logic                     filtered_valid,
  input  logic                     filtered_stall,
  output logic signed [FILT_W-1:0] filtered
);

  cthr_cmd_t    cmd;
  cthr_status_t status;

  cthr_ctrl #(
    .TEMPLATE_LEN(TEMPLATE_LEN)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .filtered_valid(filtered_valid),
    .filtered_stall(filtered_stall),
    .status        (status),
    .cmd           (cmd)
  );

  cthr_dp #(
    .SPACING     (SPACING),
    .TEMPLATE_LEN(TEMPLATE_LEN)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .filtered(filtered),
    .cmd     (cmd),
    .status  (status)
  );

  `CTHR_ASSERT_IMPL(a_load_into_free_reg, clk, rst, cmd.load_out, !filtered_valid || !filtered_stall)
  `CTHR_ASSERT_NEXT(a_warm_item_busy, clk, rst, cmd.accept && status.warm, sample_stall)
  `CTHR_ASSERT_IMPL(a_valid_from_load, clk, rst, $rose(filtered_valid), $past(cmd.load_out))

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for coherent_template_hum_removal: random and shaped sample streams,
// random idling on both sides, results checked against an in-bench template predictor
// depends on cthr_pkg and the coherent_template_hum_removal rtl
`default_nettype none

module tb_top
  import cthr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_LEN   = SPACING_DEF * (2 * TEMPLATE_LEN_DEF - 1);
  localparam int HALF       = SPACING_DEF * (TEMPLATE_LEN_DEF - 1);
  localparam int N_ITEMS    = 1150;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LONG  = 3000;

  class hum_template_model;
    logic [SAMPLE_W-1:0]      ring [RING_LEN];
    int unsigned              wr_ptr;
    bit                       warm;
    logic signed [FILT_W-1:0] expected_filtered [$];
    int                       errors;

    function new();
      wr_ptr = 0;
      warm   = 1'b0;
      errors = 0;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s);
      int unsigned sum;
      int unsigned idx;
      int          k;
      int          diff;
      ring[wr_ptr] = s;
      if (wr_ptr == HALF) warm = 1'b1;
      if (warm) begin
        sum = 0;
        for (k = 0; k < TEMPLATE_LEN_DEF; k++) begin
          idx = (wr_ptr + RING_LEN - (SPACING_DEF * k) % RING_LEN) % RING_LEN;
          sum += ring[idx];
        end
        diff = int'(ring[(wr_ptr + RING_LEN - HALF) % RING_LEN]) - int'(sum / TEMPLATE_LEN_DEF);
        expected_filtered.push_back(diff[FILT_W-1:0]);
      end
      wr_ptr = (wr_ptr + 1) % RING_LEN;
    endfunction

    function void check_filtered(logic signed [FILT_W-1:0] got);
      logic signed [FILT_W-1:0] want;
      if (expected_filtered.size() == 0) begin
        $display("%0t: filtered result with none expected, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = expected_filtered.pop_front();
        if (got !== want) begin
          $display("%0t: filtered mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic [SAMPLE_W-1:0]      sample = '0;
  logic                     filtered_valid;
  logic                     filtered_stall = 1'b0;
  logic signed [FILT_W-1:0] filtered;

  hum_template_model hum_model = new();
  int results_seen = 0;
  int idle_cycles  = 0;

  coherent_template_hum_removal #(
    .SPACING      (SPACING_DEF),
    .TEMPLATE_LEN (TEMPLATE_LEN_DEF)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .filtered_valid (filtered_valid),
    .filtered_stall (filtered_stall),
    .filtered       (filtered)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(31, 300);
  endfunction

  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 12);
    return $urandom_range(100, 800);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'hff;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit drain);
    int gap;
    sample_valid <= 1'b1;
    sample       <= v;
    do @(posedge clk); while (sample_stall);
    gap = pick_gap();
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && hum_model.expected_filtered.size() != 0) @(posedge clk);
    end
  endtask

  // accepted items on both channels, plus the no-progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) hum_model.take_sample(sample);
      if (filtered_valid && !filtered_stall) begin
        hum_model.check_filtered(filtered);
        results_seen++;
      end
      if ((sample_valid && !sample_stall) || (filtered_valid && !filtered_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver stalls, with one long hold-off once results are flowing
  initial begin : receiver
    bit long_done;
    int hold;
    long_done = 1'b0;
    forever begin
      filtered_stall <= 1'b0;
      repeat (pick_run()) @(posedge clk);
      if (!long_done && results_seen >= 150) begin
        long_done = 1'b1;
        filtered_stall <= 1'b1;
        repeat (HOLD_LONG) @(posedge clk);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          filtered_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [SAMPLE_W-1:0] directed [$];
    logic [SAMPLE_W-1:0] base [SPACING_DEF];
    int n;
    int kind;
    int len;
    int k;
    int j;
    bit drain;
    directed = '{8'h00, 8'hff, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                 8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f,
                 8'h55, 8'haa, 8'h00, 8'hff, 8'h00, 8'hff};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    n = 0;
    foreach (directed[i]) begin
      send_sample(directed[i], 1'b0);
      n++;
    end
    while (n < N_ITEMS) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(10, 200);
      for (k = 0; k < SPACING_DEF; k++) base[k] = SAMPLE_W'($urandom_range(0, 255));
      for (j = 0; j < len && n < N_ITEMS; j++) begin
        drain = (n == 700) || ($urandom_range(0, 299) == 0);
        k = n % SPACING_DEF;
        case (kind)
          0, 1:    send_sample(SAMPLE_W'($urandom_range(0, 255)), drain);
          2:       send_sample(base[0][0] ? 8'hff : 8'h00, drain);
          3:       send_sample(k[0] ? 8'hff : 8'h00, drain);
          default: begin
            // mains-like hum with noise and the odd spike
            if ($urandom_range(0, 49) == 0)
              send_sample(clamp_sample(int'(base[k]) + $urandom_range(60, 200)), drain);
            else
              send_sample(clamp_sample(int'(base[k]) + $urandom_range(0, 8) - 4), drain);
          end
        endcase
        n++;
      end
    end
    sample_valid <= 1'b0;
    while (hum_model.expected_filtered.size() != 0) @(posedge clk);
    repeat (TEMPLATE_LEN_DEF + 40) @(posedge clk);
    if (hum_model.errors == 0 && hum_model.expected_filtered.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/cthr_pkg.sv
src/cthr_ctrl.sv
src/cthr_dp.sv
src/coherent_template_hum_removal.sv
test/tb_top.sv
